### rtl/core/assert_macros.svh
// Assertion helpers; the using module provides clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/gsrf_pkg.sv
// ----------------------------------------------------------------------------
// gsrf_pkg
// Shared constants, codes and helpers of the graphics state redundancy filter.
// ----------------------------------------------------------------------------
`default_nettype none

package gsrf_pkg;

	localparam int NEST_WIDTH = 8;
	localparam logic [NEST_WIDTH-1:0] NEST_MAX = {NEST_WIDTH{1'b1}};
	localparam logic [NEST_WIDTH-1:0] NEST_ONE = {{(NEST_WIDTH-1){1'b0}}, 1'b1};

	localparam int NSLOT = 9;
	localparam int S_X    = 0;
	localparam int S_Y    = 1;
	localparam int S_GRAY = 2;
	localparam int S_WIDTH = 3;
	localparam int S_ON1  = 4;
	localparam int S_OFF1 = 5;
	localparam int S_ON2  = 6;
	localparam int S_OFF2 = 7;
	localparam int S_FONT = 8;

	localparam int ACTION_W = 4;
	localparam logic [ACTION_W-1:0] ACT_OPAQUE   = 4'd0;
	localparam logic [ACTION_W-1:0] ACT_PATH     = 4'd1;
	localparam logic [ACTION_W-1:0] ACT_NOP      = 4'd2;
	localparam logic [ACTION_W-1:0] ACT_FONT     = 4'd3;
	localparam logic [ACTION_W-1:0] ACT_GSAVE    = 4'd4;
	localparam logic [ACTION_W-1:0] ACT_GRESTORE = 4'd5;
	localparam logic [ACTION_W-1:0] ACT_LINETO   = 4'd6;
	localparam logic [ACTION_W-1:0] ACT_MOVETO   = 4'd7;
	localparam logic [ACTION_W-1:0] ACT_DASH     = 4'd8;
	localparam logic [ACTION_W-1:0] ACT_GRAY     = 4'd9;
	localparam logic [ACTION_W-1:0] ACT_WIDTH    = 4'd10;

	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 16;
	localparam logic [CFG_INDEX_W-1:0] CFG_OPTIMIZE  = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_TOLERANCE = 1'b1;
	localparam logic [CFG_DATA_W-1:0]  TOL_RESET     = 16'd7;

	localparam int IN_DATA_W  = 128;
	localparam int OUT_DATA_W = 136;
	localparam int OUT_USER_W = 2;

	typedef logic signed [31:0] value_t;
	typedef logic signed [32:0] diff_t;

	function automatic diff_t sub33(input value_t x, input value_t y);
		return {x[31], x} - {y[31], y};
	endfunction

	// |x - y| < tol, computed exactly
	function automatic logic near(input value_t x, input value_t y,
			input logic [CFG_DATA_W-1:0] tol);
		diff_t d;
		logic [32:0] m;
		d = sub33(x, y);
		m = d[32] ? (33'd0 - d) : d;
		return m < {17'd0, tol};
	endfunction

endpackage

`default_nettype wire

### rtl/core/graphics_state_redundancy_filter_core.sv
// ----------------------------------------------------------------------------
// graphics_state_redundancy_filter_core
// Cached graphics state tracker that flags redundant drawing commands.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_*: one drawing command per transaction, the action code in
//   s_tuser and the four Q16.16 arguments in s_tdata.
//   Master stream m_*: exactly one result per command, in order; m_tuser
//   carries emit and solid_dash, m_tdata the four dash segment lengths.
//   Configuration: cfg_we/cfg_index/cfg_wdata, write only while idle.
// Path: a command accepted at s_* passes the input register, then the result
//   register, before its result appears at m_*.
// Throughput: one command per cycle while m_tready is high; all compares
//   against the nine cached slots run in parallel between the two registers.
// Reset: every cached value is unknown, nesting level 0 and unknown,
//   optimize_on = 1, match_tolerance = 7; both registers empty.
// Stall: with m_tready low and m_tvalid high the result register holds, the
//   input register fills, and s_tready drops; no transaction is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module graphics_state_redundancy_filter_core (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   s_tvalid,
	output logic                                        s_tready,
	// s_tdata: arg_a[31:0], arg_b[63:32], arg_c[95:64], arg_d[127:96]
	input  wire logic [gsrf_pkg::IN_DATA_W-1:0]         s_tdata,
	// s_tuser: action[3:0]
	input  wire logic [gsrf_pkg::ACTION_W-1:0]          s_tuser,
	output logic                                        m_tvalid,
	input  wire logic                                   m_tready,
	// m_tdata: seg_on1[31:0], seg_off1[64:32], seg_on2[97:65],
	//          seg_off2[130:98], zero[135:131]
	output logic [gsrf_pkg::OUT_DATA_W-1:0]             m_tdata,
	// m_tuser: emit[0], solid_dash[1]
	output logic [gsrf_pkg::OUT_USER_W-1:0]             m_tuser,
	input  wire logic                                   cfg_we,
	input  wire logic [gsrf_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  wire logic [gsrf_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

	logic                                 optimize_on_q;
	logic [gsrf_pkg::CFG_DATA_W-1:0]      match_tolerance_q;

	logic                                 valid_s1;
	logic [gsrf_pkg::ACTION_W-1:0]        action_s1;
	gsrf_pkg::value_t                     arg_a_s1, arg_b_s1, arg_c_s1, arg_d_s1;

	logic                                 valid_s2;
	logic                                 emit_s2, solid_s2;
	gsrf_pkg::value_t                     seg_on1_s2;
	gsrf_pkg::diff_t                      seg_off1_s2, seg_on2_s2, seg_off2_s2;

	gsrf_pkg::value_t                     cur_values_q   [gsrf_pkg::NSLOT];
	gsrf_pkg::value_t                     saved_values_q [gsrf_pkg::NSLOT];
	logic [gsrf_pkg::NSLOT-1:0]           cur_known_q, saved_known_q;
	logic [gsrf_pkg::NEST_WIDTH-1:0]      nest_level_q;
	logic                                 nest_known_q;

	logic                                 load_s2, adv_s1;
	logic [gsrf_pkg::NSLOT-1:0]           slot_hit;
	gsrf_pkg::value_t                     slot_arg [gsrf_pkg::NSLOT];
	logic                                 same, solid, is_dash, snap, restore;

	// handshake
	assign load_s2  = !valid_s2 || m_tready;
	assign adv_s1   = valid_s1 && load_s2;
	assign s_tready = !valid_s1 || load_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			optimize_on_q     <= 1'b1;
			match_tolerance_q <= gsrf_pkg::TOL_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				gsrf_pkg::CFG_OPTIMIZE:  optimize_on_q     <= cfg_wdata[0];
				gsrf_pkg::CFG_TOLERANCE: match_tolerance_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			action_s1 <= s_tuser;
			arg_a_s1  <= s_tdata[31:0];
			arg_b_s1  <= s_tdata[63:32];
			arg_c_s1  <= s_tdata[95:64];
			arg_d_s1  <= s_tdata[127:96];
		end
	end

	// compare every cached slot against the argument that would set it
	always_comb begin
		slot_arg[gsrf_pkg::S_X]     = arg_a_s1;
		slot_arg[gsrf_pkg::S_Y]     = arg_b_s1;
		slot_arg[gsrf_pkg::S_GRAY]  = arg_a_s1;
		slot_arg[gsrf_pkg::S_WIDTH] = arg_a_s1;
		slot_arg[gsrf_pkg::S_ON1]   = arg_a_s1;
		slot_arg[gsrf_pkg::S_OFF1]  = arg_b_s1;
		slot_arg[gsrf_pkg::S_ON2]   = arg_c_s1;
		slot_arg[gsrf_pkg::S_OFF2]  = arg_d_s1;
		slot_arg[gsrf_pkg::S_FONT]  = arg_a_s1;
	end

	for (genvar i = 0; i < gsrf_pkg::NSLOT; i++) begin : g_hit
		assign slot_hit[i] = cur_known_q[i] &&
			gsrf_pkg::near(slot_arg[i], cur_values_q[i], match_tolerance_q);
	end

	always_comb begin
		case (action_s1)
			gsrf_pkg::ACT_FONT:  same = slot_hit[gsrf_pkg::S_FONT];
			gsrf_pkg::ACT_GRAY:  same = slot_hit[gsrf_pkg::S_GRAY];
			gsrf_pkg::ACT_WIDTH: same = slot_hit[gsrf_pkg::S_WIDTH];
			gsrf_pkg::ACT_LINETO,
			gsrf_pkg::ACT_MOVETO:
				same = slot_hit[gsrf_pkg::S_X] && slot_hit[gsrf_pkg::S_Y];
			gsrf_pkg::ACT_DASH:
				same = slot_hit[gsrf_pkg::S_ON1] && slot_hit[gsrf_pkg::S_OFF1] &&
					slot_hit[gsrf_pkg::S_ON2] && slot_hit[gsrf_pkg::S_OFF2];
			default: same = 1'b0;
		endcase
	end

	assign is_dash = (action_s1 == gsrf_pkg::ACT_DASH);
	assign solid = is_dash &&
		gsrf_pkg::near(arg_a_s1, '0, match_tolerance_q) &&
		gsrf_pkg::near(arg_b_s1, '0, match_tolerance_q) &&
		gsrf_pkg::near(arg_c_s1, '0, match_tolerance_q) &&
		gsrf_pkg::near(arg_d_s1, '0, match_tolerance_q);
	assign snap    = (action_s1 == gsrf_pkg::ACT_GSAVE) &&
		!(nest_known_q && nest_level_q != '0);
	assign restore = (action_s1 == gsrf_pkg::ACT_GRESTORE) &&
		nest_known_q && nest_level_q == gsrf_pkg::NEST_ONE;

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			emit_s2     <= !(optimize_on_q && same);
			solid_s2    <= solid;
			seg_on1_s2  <= is_dash ? arg_a_s1 : '0;
			seg_off1_s2 <= is_dash ? gsrf_pkg::sub33(arg_b_s1, arg_a_s1) : '0;
			seg_on2_s2  <= is_dash ? gsrf_pkg::sub33(arg_c_s1, arg_b_s1) : '0;
			seg_off2_s2 <= is_dash ? gsrf_pkg::sub33(arg_d_s1, arg_c_s1) : '0;
		end
	end

	// known bits and nesting counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_known_q  <= '0;
			nest_level_q <= '0;
			nest_known_q <= 1'b0;
		end else if (adv_s1) begin
			case (action_s1)
				gsrf_pkg::ACT_OPAQUE: begin
					cur_known_q  <= '0;
					nest_known_q <= 1'b0;
				end
				gsrf_pkg::ACT_PATH: begin
					cur_known_q[gsrf_pkg::S_X] <= 1'b0;
					cur_known_q[gsrf_pkg::S_Y] <= 1'b0;
				end
				gsrf_pkg::ACT_FONT:  cur_known_q[gsrf_pkg::S_FONT]  <= 1'b1;
				gsrf_pkg::ACT_GRAY:  cur_known_q[gsrf_pkg::S_GRAY]  <= 1'b1;
				gsrf_pkg::ACT_WIDTH: cur_known_q[gsrf_pkg::S_WIDTH] <= 1'b1;
				gsrf_pkg::ACT_LINETO,
				gsrf_pkg::ACT_MOVETO: begin
					cur_known_q[gsrf_pkg::S_X] <= 1'b1;
					cur_known_q[gsrf_pkg::S_Y] <= 1'b1;
				end
				gsrf_pkg::ACT_DASH: begin
					cur_known_q[gsrf_pkg::S_ON1]  <= 1'b1;
					cur_known_q[gsrf_pkg::S_OFF1] <= 1'b1;
					cur_known_q[gsrf_pkg::S_ON2]  <= 1'b1;
					cur_known_q[gsrf_pkg::S_OFF2] <= 1'b1;
				end
				gsrf_pkg::ACT_GSAVE: begin
					if (snap) begin
						nest_level_q <= gsrf_pkg::NEST_ONE;
						nest_known_q <= 1'b1;
					end else if (nest_level_q != gsrf_pkg::NEST_MAX) begin
						nest_level_q <= nest_level_q + gsrf_pkg::NEST_ONE;
					end
				end
				gsrf_pkg::ACT_GRESTORE: begin
					if (restore) begin
						nest_level_q <= '0;
						cur_known_q  <= saved_known_q;
					end else begin
						if (nest_known_q && nest_level_q != '0) begin
							nest_level_q <= nest_level_q - gsrf_pkg::NEST_ONE;
						end
						cur_known_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// cached values and save stack
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			case (action_s1)
				gsrf_pkg::ACT_FONT:  cur_values_q[gsrf_pkg::S_FONT]  <= arg_a_s1;
				gsrf_pkg::ACT_GRAY:  cur_values_q[gsrf_pkg::S_GRAY]  <= arg_a_s1;
				gsrf_pkg::ACT_WIDTH: cur_values_q[gsrf_pkg::S_WIDTH] <= arg_a_s1;
				gsrf_pkg::ACT_LINETO,
				gsrf_pkg::ACT_MOVETO: begin
					cur_values_q[gsrf_pkg::S_X] <= arg_a_s1;
					cur_values_q[gsrf_pkg::S_Y] <= arg_b_s1;
				end
				gsrf_pkg::ACT_DASH: begin
					cur_values_q[gsrf_pkg::S_ON1]  <= arg_a_s1;
					cur_values_q[gsrf_pkg::S_OFF1] <= arg_b_s1;
					cur_values_q[gsrf_pkg::S_ON2]  <= arg_c_s1;
					cur_values_q[gsrf_pkg::S_OFF2] <= arg_d_s1;
				end
				gsrf_pkg::ACT_GSAVE: begin
					if (snap) begin
						saved_values_q <= cur_values_q;
						saved_known_q  <= cur_known_q;
					end
				end
				gsrf_pkg::ACT_GRESTORE: begin
					if (restore) begin
						cur_values_q <= saved_values_q;
					end
				end
				default: ;
			endcase
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = {solid_s2, emit_s2};
	assign m_tdata  = {5'd0, seg_off2_s2, seg_on2_s2, seg_off1_s2, seg_on1_s2};

	`ASSERT_NEXT(a_adv_gives_result, adv_s1, m_tvalid, "advanced command produced no result")
	`ASSERT_IMPL(a_drop_needs_optimize, m_tvalid && !m_tuser[0], optimize_on_q,
		"command dropped with optimization off")
	`ASSERT_NEXT(a_opaque_forgets, adv_s1 && action_s1 == gsrf_pkg::ACT_OPAQUE,
		!nest_known_q && cur_known_q == '0, "opaque command left state known")
	`ASSERT_NEXT(a_nest_saturates,
		adv_s1 && action_s1 == gsrf_pkg::ACT_GSAVE && nest_known_q &&
		nest_level_q == gsrf_pkg::NEST_MAX,
		nest_level_q == gsrf_pkg::NEST_MAX, "nesting counter wrapped")

endmodule

`default_nettype wire
